>>> design/sla_pkg.sv
package sla_pkg;

    localparam int ModeW    = 2;
    localparam int ByteW    = 8;
    localparam int IdxW     = 10;
    localparam int LenOutW  = 11;
    localparam int CntW     = 32;
    localparam int TimeoutW = 16;
    localparam int IdleW    = 17;

    localparam int InDataW  = 24;
    localparam int InUserW  = 2;
    localparam int OutDataW = 152;
    localparam int OutUserW = 4;

    localparam logic [ByteW-1:0]    CHAR_LF       = 8'h0A;
    localparam logic [ByteW-1:0]    CHAR_CR       = 8'h0D;
    localparam logic [TimeoutW-1:0] TIMEOUT_RESET = 16'd500;

    typedef enum logic [1:0] {
        MODE_BYTE = 2'd0,
        MODE_TICK = 2'd1,
        MODE_READ = 2'd2,
        MODE_NONE = 2'd3
    } t_sla_mode;

    typedef enum logic [2:0] {
        KIND_BYTE = 3'd0,
        KIND_TERM = 3'd1,
        KIND_TICK = 3'd2,
        KIND_READ = 3'd3,
        KIND_NONE = 3'd4
    } t_sla_kind;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_STORED   = 3'd1,
        EV_LINE     = 3'd2,
        EV_OVERFLOW = 3'd3,
        EV_DROPPED  = 3'd4,
        EV_RESYNC   = 3'd5
    } t_sla_event;

    typedef struct packed {
        t_sla_kind         kind;
        logic [ByteW-1:0]  data;
        logic [IdxW-1:0]   index;
    } t_sla_cmd;

    typedef struct packed {
        t_sla_event          event_res;
        logic                timed_out;
        logic [LenOutW-1:0]  line_length;
        logic [CntW-1:0]     dropped_count;
        logic [ByteW-1:0]    read_data;
        logic [CntW-1:0]     overflow_total;
        logic [CntW-1:0]     timeout_total;
        logic [CntW-1:0]     resync_total;
    } t_sla_result;

endpackage

>>> design/sla_ram.sv
module sla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/sla_front.sv
module sla_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [sla_pkg::ModeW-1:0] i_mode,
    input  logic [sla_pkg::ByteW-1:0] i_rx_byte,
    input  logic [sla_pkg::IdxW-1:0]  i_read_index,
    output logic                     o_cmd_valid,
    output sla_pkg::t_sla_cmd        o_cmd,
    input  logic                     i_cmd_ready
);
    import sla_pkg::*;

    localparam int Depth = 4;
    localparam int PtrW  = $clog2(Depth);

    t_sla_cmd        r_queue [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [PtrW:0]   r_count;
    t_sla_cmd        cmd_in;
    logic            push;
    logic            pop;

    // Classify the word before it is queued so the back end sees one kind code.
    always_comb begin
        cmd_in.data  = i_rx_byte;
        cmd_in.index = i_read_index;
        case (t_sla_mode'(i_mode))
            MODE_BYTE: begin
                cmd_in.kind = (i_rx_byte inside {CHAR_LF, CHAR_CR}) ? KIND_TERM : KIND_BYTE;
            end
            MODE_TICK: begin
                cmd_in.kind = KIND_TICK;
            end
            MODE_READ: begin
                cmd_in.kind = KIND_READ;
            end
            default: begin
                cmd_in.kind = KIND_NONE;
            end
        endcase
    end

    assign o_ready     = (r_count != (PtrW+1)'(Depth));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_queue[r_rd_ptr];
    assign push        = i_valid && o_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

>>> design/sla_back.sv
module sla_back #(
    parameter int LINE_MAX = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [sla_pkg::TimeoutW-1:0] i_cfg_wdata,
    input  logic                         i_cmd_valid,
    input  sla_pkg::t_sla_cmd            i_cmd,
    output logic                         o_cmd_ready,
    output logic                         o_res_valid,
    output sla_pkg::t_sla_result         o_res,
    input  logic                         i_res_ready
);
    import sla_pkg::*;

    localparam int LW = $clog2(LINE_MAX + 1);
    localparam int AW = $clog2(LINE_MAX);
    localparam logic [LW-1:0] LenMax = LW'(LINE_MAX);
    localparam logic [LW-1:0] LenOne = LW'(1);

    logic [TimeoutW-1:0] r_timeout_ms;
    logic [LW-1:0]       r_line_len,   n_line_len;
    logic                r_dropping,   n_dropping;
    logic [CntW-1:0]     r_drop_count, n_drop_count;
    logic [IdleW-1:0]    r_idle_ms,    n_idle_ms;
    logic [CntW-1:0]     r_ovf_cnt,    n_ovf_cnt;
    logic [CntW-1:0]     r_tmo_cnt,    n_tmo_cnt;
    logic [CntW-1:0]     r_rsy_cnt,    n_rsy_cnt;

    logic                r_s1_valid;
    t_sla_result         r_s1_res;
    logic                r_s1_hit;
    logic                r_out_valid;
    t_sla_result         r_out_res;

    logic                out_free;
    logic                s1_free;
    logic                pop;
    logic                is_rx;
    logic                tmo;
    logic [LW-1:0]       len_e;
    logic                drop_e;
    logic [CntW-1:0]     dc_e;
    logic [LW-1:0]       len_out;
    logic                len_fixed;
    logic [LW+IdxW-1:0]  idx_wide;
    logic [LW+IdxW-1:0]  len_wide;
    logic [LW+LenOutW-1:0] len_ext;
    t_sla_event          ev;
    logic [CntW-1:0]     dcount;
    logic                hit;
    logic                ram_we;
    logic                ram_re;
    logic [ByteW-1:0]    ram_rdata;
    t_sla_result         res;
    t_sla_result         s1_out;

    sla_ram #(
        .WIDTH (ByteW),
        .DEPTH (LINE_MAX)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (len_e[AW-1:0]),
        .i_wdata (i_cmd.data),
        .i_re    (ram_re),
        .i_raddr (idx_wide[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign out_free    = !r_out_valid || i_res_ready;
    assign s1_free     = !r_s1_valid || out_free;
    assign o_cmd_ready = s1_free;
    assign pop         = i_cmd_valid && s1_free;

    assign is_rx    = (i_cmd.kind == KIND_BYTE) || (i_cmd.kind == KIND_TERM);
    // A byte after too long a silence discards a partial or dropping line first.
    assign tmo      = is_rx && ((r_line_len != '0) || r_dropping)
                      && (r_idle_ms > {1'b0, r_timeout_ms});
    assign len_e    = tmo ? '0 : r_line_len;
    assign drop_e   = tmo ? 1'b0 : r_dropping;
    assign dc_e     = tmo ? '0 : r_drop_count;
    assign idx_wide = {{LW{1'b0}}, i_cmd.index};
    assign len_wide = {{IdxW{1'b0}}, r_line_len};

    always_comb begin
        n_line_len   = r_line_len;
        n_dropping   = r_dropping;
        n_drop_count = r_drop_count;
        n_idle_ms    = r_idle_ms;
        n_ovf_cnt    = r_ovf_cnt;
        n_tmo_cnt    = r_tmo_cnt;
        n_rsy_cnt    = r_rsy_cnt;
        ev           = EV_NONE;
        dcount       = '0;
        len_fixed    = 1'b0;
        hit          = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        if (pop) begin
            case (i_cmd.kind)
                KIND_BYTE, KIND_TERM: begin
                    if (tmo) begin
                        n_tmo_cnt = r_tmo_cnt + 32'd1;
                    end
                    n_idle_ms    = '0;
                    n_line_len   = len_e;
                    n_dropping   = drop_e;
                    n_drop_count = dc_e;
                    if (i_cmd.kind == KIND_TERM) begin
                        if (drop_e) begin
                            ev           = EV_RESYNC;
                            n_rsy_cnt    = r_rsy_cnt + 32'd1;
                            dcount       = dc_e;
                            n_drop_count = '0;
                        end else if (len_e != '0) begin
                            ev        = EV_LINE;
                            len_fixed = 1'b1;
                        end
                        n_line_len = '0;
                        n_dropping = 1'b0;
                    end else if (drop_e) begin
                        n_drop_count = dc_e + 32'd1;
                        ev           = EV_DROPPED;
                    end else if (len_e < LenMax) begin
                        ram_we     = 1'b1;
                        n_line_len = len_e + LenOne;
                        ev         = EV_STORED;
                    end else begin
                        n_ovf_cnt    = r_ovf_cnt + 32'd1;
                        n_line_len   = '0;
                        n_dropping   = 1'b1;
                        n_drop_count = '0;
                        ev           = EV_OVERFLOW;
                    end
                end
                KIND_TICK: begin
                    if (r_idle_ms <= {1'b0, r_timeout_ms}) begin
                        n_idle_ms = r_idle_ms + 17'd1;
                    end
                end
                KIND_READ: begin
                    ram_re = 1'b1;
                    hit    = (idx_wide < len_wide);
                end
                default: begin
                end
            endcase
        end
        len_out = len_fixed ? len_e : n_line_len;
    end

    assign len_ext = {{LenOutW{1'b0}}, len_out};

    always_comb begin
        res.event_res      = ev;
        res.timed_out      = tmo;
        res.line_length    = len_ext[LenOutW-1:0];
        res.dropped_count  = dcount;
        res.read_data      = '0;
        res.overflow_total = n_ovf_cnt;
        res.timeout_total  = n_tmo_cnt;
        res.resync_total   = n_rsy_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ms <= TIMEOUT_RESET;
            r_line_len   <= '0;
            r_dropping   <= 1'b0;
            r_drop_count <= '0;
            r_idle_ms    <= '0;
            r_ovf_cnt    <= '0;
            r_tmo_cnt    <= '0;
            r_rsy_cnt    <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout_ms <= i_cfg_wdata;
            end
            r_line_len   <= n_line_len;
            r_dropping   <= n_dropping;
            r_drop_count <= n_drop_count;
            r_idle_ms    <= n_idle_ms;
            r_ovf_cnt    <= n_ovf_cnt;
            r_tmo_cnt    <= n_tmo_cnt;
            r_rsy_cnt    <= n_rsy_cnt;
            if (s1_free) begin
                r_s1_valid <= pop;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // The read data of a stored-byte read arrives from the RAM while the word sits
    // in the first result stage; the RAM holds it until the next read.
    always_comb begin
        s1_out           = r_s1_res;
        s1_out.read_data = r_s1_hit ? ram_rdata : '0;
    end

    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1_res <= res;
            r_s1_hit <= hit;
        end
        if (out_free) begin
            r_out_res <= s1_out;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out_res;

endmodule

>>> design/serial_line_assembler.sv
// Channel   Direction  Ports               tdata fields (low bit up)           tuser fields
// ------    ---------  ------------------  ----------------------------------  ---------------
// input     slave      s_axis_*            rx_byte, read_index                 mode
// result    master     m_axis_*            line_length, dropped_count,         event_res,
//                                          read_data, overflow_total,          timed_out
//                                          timeout_total, resync_total
// config    write      i_cfg_we/i_cfg_wdata timeout_ms
//
// One word is accepted per cycle while the output does not stall, and each gives one result
// word; a word passes from input to output through the queue (classify and queue), the
// first result stage (state update) and the output register (with the read data). The rate
// is set by the single state-update step in the back end.
// Reset is synchronous and clears all counters and the line state; the line RAM is
// not cleared and needs no clearing pass. A stall at the output fills the result
// stages and then the four-word queue before s_axis_tready drops.
module serial_line_assembler #(
    parameter int LINE_MAX = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [sla_pkg::TimeoutW-1:0] i_cfg_wdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // rx_byte [7:0], read_index [17:8], zero [23:18]
    input  logic [sla_pkg::InDataW-1:0]  s_axis_tdata,
    // mode [1:0]
    input  logic [sla_pkg::InUserW-1:0]  s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // line_length [10:0], dropped_count [42:11], read_data [50:43],
    // overflow_total [82:51], timeout_total [114:83], resync_total [146:115], zero [151:147]
    output logic [sla_pkg::OutDataW-1:0] m_axis_tdata,
    // event_res [2:0], timed_out [3]
    output logic [sla_pkg::OutUserW-1:0] m_axis_tuser
);
    import sla_pkg::*;

    logic        cmd_valid;
    logic        cmd_ready;
    t_sla_cmd    cmd;
    t_sla_result res;

    sla_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_mode       (s_axis_tuser[ModeW-1:0]),
        .i_rx_byte    (s_axis_tdata[ByteW-1:0]),
        .i_read_index (s_axis_tdata[ByteW+IdxW-1:ByteW]),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_ready  (cmd_ready)
    );

    sla_back #(
        .LINE_MAX (LINE_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .o_res_valid (m_axis_tvalid),
        .o_res       (res),
        .i_res_ready (m_axis_tready)
    );

    assign m_axis_tdata = {5'b0, res.resync_total, res.timeout_total, res.overflow_total,
                           res.read_data, res.dropped_count, res.line_length};
    assign m_axis_tuser = {res.timed_out, res.event_res};

endmodule

>>> design/sla_checker.sv
module sla_port_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [sla_pkg::OutDataW-1:0] m_axis_tdata,
    input logic [sla_pkg::OutUserW-1:0] m_axis_tuser
);
    import sla_pkg::*;

    // A stalled result word keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    a_event_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser[2:0] <= EV_RESYNC)
        else $error("event code out of range");

    // The drop count is only reported together with a resync.
    a_drop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser[2:0] != EV_RESYNC) |-> m_axis_tdata[42:11] == '0)
        else $error("dropped count shown without resync");

    // Results that carry an event or the timeout flag, which come only from received bytes, never carry read data.
    a_rx_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && ((m_axis_tuser[2:0] != EV_NONE) || m_axis_tuser[3])
        |-> m_axis_tdata[50:43] == '0)
        else $error("read data on a byte result");

endmodule

bind serial_line_assembler sla_port_checker u_sla_port_checker (.*);
